// File: hw/rtl/butterworth_bandpass_biquad_cascade_macros.svh
// Assertion macros for the band-pass biquad cascade.
// Used at the end of the top level; expects clk and rst_n in scope.
`ifndef BUTTERWORTH_BANDPASS_BIQUAD_CASCADE_MACROS_SVH
`define BUTTERWORTH_BANDPASS_BIQUAD_CASCADE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BBQ_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BBQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/bbq_pkg.sv
// Shared constants, types and helpers of the band-pass biquad cascade.
// No dependencies; imported by the interfaces, the multiplier and the top level.
package bbq_pkg;

  localparam int DEF_SAMPLE_WIDTH = 16;
  localparam int NUM_SECTIONS     = 4;
  localparam int COEF_PER_SEC     = 5;
  localparam int NUM_COEF         = NUM_SECTIONS * COEF_PER_SEC;
  localparam int SEC_W            = $clog2(NUM_SECTIONS);
  localparam int CIDX_W           = $clog2(NUM_COEF);

  localparam int COEF_W    = 32;   // Q3.28
  localparam int COEF_FRAC = 28;
  localparam int DELAY_W   = 40;   // Q23.16
  localparam int DELAY_FRAC = 16;
  localparam int ZSPLIT    = 20;   // operand split point for the shared multiplier
  localparam int HALF_W    = ZSPLIT + 1;
  localparam int MUL_W     = COEF_W + HALF_W;
  localparam int FULL_W    = COEF_W + DELAY_W + 2;
  localparam int PROD_W    = 44;   // rounded coefficient product
  localparam int ACC_W     = 48;

  // Coefficient step inside one section.
  localparam logic [2:0] K_A1 = 3'd0;
  localparam logic [2:0] K_A2 = 3'd1;
  localparam logic [2:0] K_B0 = 3'd2;
  localparam logic [2:0] K_B1 = 3'd3;
  localparam logic [2:0] K_B2 = 3'd4;

  localparam logic signed [ACC_W-1:0] DELAY_MAX = ACC_W'((64'sd1 <<< (DELAY_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] DELAY_MIN = ACC_W'(-(64'sd1 <<< (DELAY_W - 1)));

  // a1, a2, b0, b1, b2 per section, Q3.28.
  localparam logic signed [COEF_W-1:0] COEF_ROM [NUM_COEF] = '{
    -32'sd198496549, 32'sd160855942, 32'sd599924,    32'sd1199847,   32'sd599924,
    -32'sd278607077, 32'sd172019856, 32'sd268435456, 32'sd536870912, 32'sd268435456,
    -32'sd158876893, 32'sd216487757, 32'sd268435456, -32'sd536870912, 32'sd268435456,
    -32'sd357874356, 32'sd229224992, 32'sd268435456, -32'sd536870912, 32'sd268435456
  };

  typedef struct packed {
    logic mul_lo;   // multiply coefficient by the low operand half
    logic mul_hi;   // multiply coefficient by the high operand half
  } mac_ctl_t;

  function automatic logic [CIDX_W-1:0] coef_idx(input logic [SEC_W-1:0] sec,
                                                 input logic [2:0] k);
    logic [CIDX_W-1:0] base;
    base = CIDX_W'(sec) * CIDX_W'(COEF_PER_SEC);
    return base + CIDX_W'(k);
  endfunction

  function automatic logic signed [DELAY_W-1:0] sat_delay(input logic signed [ACC_W-1:0] v);
    logic signed [DELAY_W-1:0] r;
    if (v > DELAY_MAX) begin
      r = DELAY_MAX[DELAY_W-1:0];
    end else if (v < DELAY_MIN) begin
      r = DELAY_MIN[DELAY_W-1:0];
    end else begin
      r = v[DELAY_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/bbq_if.sv
// Stream interfaces of the band-pass biquad cascade: sample in, sample out.
// Depends on bbq_pkg for the default sample width.
interface bbq_in_if import bbq_pkg::*; #(parameter int W = DEF_SAMPLE_WIDTH);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] sample_in;
  logic                clear_state;

  modport source (output valid, sample_in, clear_state, input ready);
  modport sink   (input valid, sample_in, clear_state, output ready);
endinterface

interface bbq_out_if import bbq_pkg::*; #(parameter int W = DEF_SAMPLE_WIDTH);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] sample_out;

  modport source (output valid, sample_out, input ready);
  modport sink   (input valid, sample_out, output ready);
endinterface

// File: hw/rtl/bbq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bbq_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/bbq_mac.sv
// Shared coefficient multiplier: two half products, then round to Q.16.
// Depends on bbq_pkg.
module bbq_mac import bbq_pkg::*; (
  input  logic                      clk,
  input  mac_ctl_t                  ctl,
  input  logic signed [COEF_W-1:0]  coef,
  input  logic signed [DELAY_W-1:0] opnd,
  output logic signed [PROD_W-1:0]  prod_q
);

  localparam logic signed [FULL_W-1:0] ROUND_HALF = FULL_W'(1) << (COEF_FRAC - 1);

  logic signed [HALF_W-1:0] half_b;
  logic signed [MUL_W-1:0]  mul_p;
  logic signed [MUL_W-1:0]  pp_lo_r;
  logic signed [MUL_W-1:0]  pp_hi_r;
  logic signed [FULL_W-1:0] full;

  // Low half is unsigned, high half carries the sign.
  assign half_b = ctl.mul_hi ? {opnd[DELAY_W-1], opnd[DELAY_W-1:ZSPLIT]}
                             : {1'b0, opnd[ZSPLIT-1:0]};
  assign mul_p  = MUL_W'(coef) * MUL_W'(half_b);

  always_ff @(posedge clk) begin
    if (ctl.mul_lo) begin
      pp_lo_r <= mul_p;
    end
    if (ctl.mul_hi) begin
      pp_hi_r <= mul_p;
    end
  end

  // Exact product plus half, then floor shift: round half up.
  assign full   = (FULL_W'(pp_hi_r) <<< ZSPLIT) + FULL_W'(pp_lo_r) + ROUND_HALF;
  assign prod_q = PROD_W'(full >>> COEF_FRAC);

endmodule

// File: hw/rtl/butterworth_bandpass_biquad_cascade.sv
// Words are filtered one at a time; a new word is taken only in ST_IDLE. Per section
// the sequencer reads the delays (ST_READ, ST_LOAD), then runs ST_MLO, ST_MHI, ST_ACC
//   for each of the 5 products on the single shared multiplier; ST_DONE waits for a free output register.
// Reset (rst_n low, synchronous) empties the output register, returns the
//   sequencer to idle and marks every section delay as zero.
// A word with clear_state set zeroes all delays before it is filtered.
module butterworth_bandpass_biquad_cascade import bbq_pkg::*; #(
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
  input  logic        clk,
  input  logic        rst_n,
  bbq_in_if.sink      in_chan,
  bbq_out_if.source   out_chan
);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE = 3'd0;  // wait for an input word
  localparam logic [2:0] ST_READ = 3'd1;  // issue delay RAM read for this section
  localparam logic [2:0] ST_LOAD = 3'd2;  // capture z1, z2 from RAM
  localparam logic [2:0] ST_MLO  = 3'd3;  // low half product
  localparam logic [2:0] ST_MHI  = 3'd4;  // high half product
  localparam logic [2:0] ST_ACC  = 3'd5;  // round product and accumulate
  localparam logic [2:0] ST_DONE = 3'd6;  // final rounding into output register

  localparam int RND_W = DELAY_W - DELAY_FRAC + 1;
  localparam logic signed [DELAY_W:0]   RND_HALF = (DELAY_W + 1)'(1) << (DELAY_FRAC - 1);
  localparam logic signed [RND_W-1:0]   OUT_MAX  =
    RND_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 1);
  localparam logic signed [RND_W-1:0]   OUT_MIN  =
    RND_W'(-(64'sd1 <<< (SAMPLE_WIDTH - 1)));

  logic [2:0]                state_r, state_nxt;
  logic [SEC_W-1:0]          sec_r, sec_nxt;
  logic [2:0]                k_r, k_nxt;
  logic [NUM_SECTIONS-1:0]   vld_r, vld_nxt;
  logic signed [DELAY_W-1:0] v_r, v_nxt;        // section input / output
  logic signed [DELAY_W-1:0] z1_r, z1_nxt;
  logic signed [DELAY_W-1:0] z2_r, z2_nxt;
  logic signed [DELAY_W-1:0] x_r, x_nxt;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_WIDTH-1:0] out_sample_r, out_sample_nxt;

  logic                      in_acc;
  logic signed [SAMPLE_WIDTH-1:0] smp;
  logic [DELAY_W-1:0]        z1_rd, z2_rd;
  logic                      ram_re, ram_we;
  logic signed [COEF_W-1:0]  coef;
  logic signed [DELAY_W-1:0] opnd;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [ACC_W-1:0]   acc_sum;
  mac_ctl_t                  mac_ctl;
  logic signed [DELAY_W:0]   rnd_sum;
  logic signed [RND_W-1:0]   rnd_q;
  logic signed [RND_W-1:0]   rnd_sat;

  assign in_chan.ready      = (state_r == ST_IDLE);
  assign in_acc             = in_chan.valid && in_chan.ready;
  assign smp                = in_chan.sample_in;
  assign out_chan.valid      = out_valid_r;
  assign out_chan.sample_out = out_sample_r;

  // Delay memories: one bank for z1, one for z2, addressed by section.
  // Each section is read in ST_READ, then written back in its last ST_ACC step before the next
  // section reads another address, so the two ports never touch one entry at once.
  assign ram_re = (state_r == ST_READ);
  assign ram_we = (state_r == ST_ACC) && (k_r == K_B2);

  bbq_ram #(.WIDTH(DELAY_W), .DEPTH(NUM_SECTIONS)) u_z1_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (sec_r),
    .wdata (x_r),
    .re    (ram_re),
    .raddr (sec_r),
    .rdata (z1_rd)
  );

  bbq_ram #(.WIDTH(DELAY_W), .DEPTH(NUM_SECTIONS)) u_z2_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (sec_r),
    .wdata (z1_r),
    .re    (ram_re),
    .raddr (sec_r),
    .rdata (z2_rd)
  );

  // Coefficient and operand for the current step.
  assign coef = COEF_ROM[coef_idx(sec_r, k_r)];

  always_comb begin
    case (k_r)
      K_A1, K_B1: opnd = z1_r;
      K_B0:       opnd = x_r;
      default:    opnd = z2_r;
    endcase
  end

  assign mac_ctl.mul_lo = (state_r == ST_MLO);
  assign mac_ctl.mul_hi = (state_r == ST_MHI);

  bbq_mac u_mac (
    .clk    (clk),
    .ctl    (mac_ctl),
    .coef   (coef),
    .opnd   (opnd),
    .prod_q (prod_q)
  );

  // Feedback terms subtract, feed-forward terms add.
  assign acc_sum = (k_r == K_A1 || k_r == K_A2) ? acc_r - ACC_W'(prod_q)
                                                : acc_r + ACC_W'(prod_q);

  // Output rounding: half up to integer, then clamp to the sample range.
  assign rnd_sum = (DELAY_W + 1)'(v_r) + RND_HALF;
  assign rnd_q   = rnd_sum[DELAY_W:DELAY_FRAC];

  always_comb begin
    if (rnd_q > OUT_MAX) begin
      rnd_sat = OUT_MAX;
    end else if (rnd_q < OUT_MIN) begin
      rnd_sat = OUT_MIN;
    end else begin
      rnd_sat = rnd_q;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    sec_nxt        = sec_r;
    k_nxt          = k_r;
    vld_nxt        = vld_r;
    v_nxt          = v_r;
    z1_nxt         = z1_r;
    z2_nxt         = z2_r;
    x_nxt          = x_r;
    acc_nxt        = acc_r;
    out_valid_nxt  = out_valid_r;
    out_sample_nxt = out_sample_r;

    // Drop the held word once the sink takes it.
    if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_chan.clear_state) begin
            vld_nxt = '0;
          end
          v_nxt     = DELAY_W'(smp) <<< DELAY_FRAC;
          sec_nxt   = '0;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        // Entries never written since reset or a clear read as zero.
        z1_nxt    = vld_r[sec_r] ? signed'(z1_rd) : '0;
        z2_nxt    = vld_r[sec_r] ? signed'(z2_rd) : '0;
        acc_nxt   = ACC_W'(v_r);
        k_nxt     = K_A1;
        state_nxt = ST_MLO;
      end
      ST_MLO: begin
        state_nxt = ST_MHI;
      end
      ST_MHI: begin
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        acc_nxt = acc_sum;
        if (k_r == K_A2) begin
          x_nxt   = sat_delay(acc_sum);
          acc_nxt = '0;
        end
        if (k_r == K_B2) begin
          // Section done: y feeds the next section, delays shift in RAM.
          v_nxt          = sat_delay(acc_sum);
          vld_nxt[sec_r] = 1'b1;
          if (sec_r == SEC_W'(NUM_SECTIONS - 1)) begin
            state_nxt = ST_DONE;
          end else begin
            sec_nxt   = sec_r + SEC_W'(1);
            state_nxt = ST_READ;
          end
        end else begin
          k_nxt     = k_r + 3'd1;
          state_nxt = ST_MLO;
        end
      end
      ST_DONE: begin
        // Hold until the output register is free.
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt  = 1'b1;
          out_sample_nxt = SAMPLE_WIDTH'(rnd_sat);
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sec_r       <= '0;
      k_r         <= K_A1;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sec_r       <= sec_nxt;
      k_r         <= k_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r          <= v_nxt;
    z1_r         <= z1_nxt;
    z2_r         <= z2_nxt;
    x_r          <= x_nxt;
    acc_r        <= acc_nxt;
    out_sample_r <= out_sample_nxt;
  end

`include "butterworth_bandpass_biquad_cascade_macros.svh"

  `BBQ_ASSERT_NEXT(a_start_first_section, in_acc, (state_r == ST_READ) && (sec_r == '0), "accepted word did not start at the first section")
  `BBQ_ASSERT_NEXT(a_clear_empties_delays, in_acc && in_chan.clear_state, vld_r == '0, "clear left a section delay marked valid")
  `BBQ_ASSERT_NEXT(a_writeback_marks_valid, ram_we, vld_r[$past(sec_r)], "delay write-back not marked valid")

endmodule
